/* hw/rtl/rmq_pkg.sv */
// shared types and constants for the matrix to quaternion converter
package rmq_pkg;

    localparam int ElemW  = 18;
    localparam int CandW  = 20;
    localparam int DiffW  = 19;
    localparam int OutMax = 131071;
    localparam int OutMin = -131072;

    typedef enum logic [1:0] {
        PART_W = 2'd0,
        PART_X = 2'd1,
        PART_Y = 2'd2,
        PART_Z = 2'd3
    } t_part;

endpackage

/* hw/rtl/rmq_front.sv */
// candidate forming, largest pick, off-diagonal terms and sqrt argument
module rmq_front #(
    parameter int FRAC_BITS = 16,
    parameter int AW        = 20
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [rmq_pkg::ElemW-1:0]  i_m [9],
    output logic        [AW-1:0]              o_arg,
    output rmq_pkg::t_part                    o_part,
    output logic signed [rmq_pkg::DiffW-1:0]  o_d [3]
);

    logic signed [rmq_pkg::CandW-1:0] r_c [4];
    logic signed [rmq_pkg::DiffW-1:0] r_s [6];
    logic signed [rmq_pkg::DiffW-1:0] n_s [6];

    always_comb begin
        n_s[0] = rmq_pkg::DiffW'(i_m[5]) - rmq_pkg::DiffW'(i_m[7]);
        n_s[1] = rmq_pkg::DiffW'(i_m[6]) - rmq_pkg::DiffW'(i_m[2]);
        n_s[2] = rmq_pkg::DiffW'(i_m[1]) - rmq_pkg::DiffW'(i_m[3]);
        n_s[3] = rmq_pkg::DiffW'(i_m[1]) + rmq_pkg::DiffW'(i_m[3]);
        n_s[4] = rmq_pkg::DiffW'(i_m[6]) + rmq_pkg::DiffW'(i_m[2]);
        n_s[5] = rmq_pkg::DiffW'(i_m[5]) + rmq_pkg::DiffW'(i_m[7]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c[0] <= rmq_pkg::CandW'(i_m[0]) + rmq_pkg::CandW'(i_m[4])
                + rmq_pkg::CandW'(i_m[8]);
            r_c[1] <= rmq_pkg::CandW'(i_m[0]) - rmq_pkg::CandW'(i_m[4])
                - rmq_pkg::CandW'(i_m[8]);
            r_c[2] <= rmq_pkg::CandW'(i_m[4]) - rmq_pkg::CandW'(i_m[0])
                - rmq_pkg::CandW'(i_m[8]);
            r_c[3] <= rmq_pkg::CandW'(i_m[8]) - rmq_pkg::CandW'(i_m[0])
                - rmq_pkg::CandW'(i_m[4]);
            r_s <= n_s;
        end
    end

    logic signed [rmq_pkg::CandW-1:0] best;
    rmq_pkg::t_part                   part;
    logic signed [AW:0]               argv;

    always_comb begin
        best = r_c[0];
        part = rmq_pkg::PART_W;
        if (r_c[1] > best) begin
            best = r_c[1];
            part = rmq_pkg::PART_X;
        end
        if (r_c[2] > best) begin
            best = r_c[2];
            part = rmq_pkg::PART_Y;
        end
        if (r_c[3] > best) begin
            best = r_c[3];
            part = rmq_pkg::PART_Z;
        end
        argv = (AW+1)'(best) + ((AW+1)'(1) <<< FRAC_BITS);
    end

    // negative sqrt argument clamps at zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_arg  <= argv[AW] ? '0 : argv[AW-1:0];
            o_part <= part;
            unique case (part)
                rmq_pkg::PART_W: o_d <= '{r_s[0], r_s[1], r_s[2]};
                rmq_pkg::PART_X: o_d <= '{r_s[3], r_s[4], r_s[0]};
                rmq_pkg::PART_Y: o_d <= '{r_s[3], r_s[5], r_s[1]};
                default:         o_d <= '{r_s[4], r_s[5], r_s[2]};
            endcase
        end
    end

endmodule

/* hw/rtl/rmq_sqrt.sv */
// pipelined integer square root, one result bit per stage
module rmq_sqrt #(
    parameter int AW = 64,
    parameter int SW = 1
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [AW-1:0]  i_a,
    input  logic [SW-1:0]  i_side,
    output logic [AW/2-1:0] o_root,
    output logic [SW-1:0]  o_side
);

    localparam int RW = AW / 2;

    logic [AW-1:0] r_rem  [RW+1];
    logic [RW-1:0] r_root [RW+1];
    logic [SW-1:0] r_side [RW+1];

    always_comb begin
        r_rem[0]  = i_a;
        r_root[0] = '0;
        r_side[0] = i_side;
    end

    for (genvar g = 0; g < RW; g++) begin : g_st
        localparam int B = RW - 1 - g;
        logic [AW-1:0] trial;
        logic [AW-1:0] cand;
        assign cand  = AW'(r_root[g]) << (B + 1);
        assign trial = cand | (AW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g+1] <= r_side[g];
                if (r_rem[g] >= trial) begin
                    r_rem[g+1]  <= r_rem[g] - trial;
                    r_root[g+1] <= r_root[g] | (RW'(1) << B);
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g];
                end
            end
        end
    end

    assign o_root = r_root[RW];
    assign o_side = r_side[RW];

endmodule

/* hw/rtl/rmq_div.sv */
// pipelined signed restoring divider, one quotient bit per stage
module rmq_div #(
    parameter int NW = 48,
    parameter int DW = 24,
    parameter int SW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [NW-1:0]  i_num,
    input  logic        [DW-1:0]  i_den,
    input  logic        [SW-1:0]  i_side,
    output logic signed [NW-1:0]  o_quo,
    output logic        [SW-1:0]  o_side
);

    logic [NW-1:0]    r_q   [NW+1];
    logic [DW:0]      r_rem [NW+1];
    logic [DW-1:0]    r_den [NW+1];
    logic             r_neg [NW+1];
    logic [SW-1:0]    r_sd  [NW+1];

    always_comb begin
        r_q[0]   = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        r_rem[0] = '0;
        r_den[0] = i_den;
        r_neg[0] = i_num[NW-1];
        r_sd[0]  = i_side;
    end

    for (genvar g = 0; g < NW; g++) begin : g_st
        logic [DW+1:0] sh;
        logic [DW+1:0] df;
        assign sh = {r_rem[g], r_q[g][NW-1]};
        assign df = sh - {2'b00, r_den[g]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g+1] <= r_den[g];
                r_neg[g+1] <= r_neg[g];
                r_sd[g+1]  <= r_sd[g];
                if (!df[DW+1]) begin
                    r_rem[g+1] <= df[DW:0];
                    r_q[g+1]   <= {r_q[g][NW-2:0], 1'b1};
                end else begin
                    r_rem[g+1] <= sh[DW:0];
                    r_q[g+1]   <= {r_q[g][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo  = r_neg[NW] ? -$signed(r_q[NW]) : $signed(r_q[NW]);
    assign o_side = r_sd[NW];

endmodule

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// top level: matrix to quaternion converter, fully pipelined
// pipeline: the two front stages, one sqrt stage per root bit, one divider stage per numerator bit,
// then the output register
// throughput: one beat per cycle; the whole pipe advances when the output can take data
// reset: synchronous active-low, clears the valid bits and the output valid only
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // col0_row0, col0_row1, col0_row2, col1_row0 .. col2_row2, 18 bits each
    input  logic [167:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, largest_part, degenerate
    output logic [79:0]   m_axis_tdata
);

    localparam int AW    = (rmq_pkg::CandW > FRAC_BITS + 1) ? rmq_pkg::CandW : FRAC_BITS + 1;
    localparam int SQ_W  = 2 * ((AW + FRAC_BITS - 2 + 1) / 2);
    localparam int RT_W  = SQ_W / 2;
    localparam int NUM_W = rmq_pkg::DiffW + FRAC_BITS + 1;
    localparam int DEN_W = RT_W + 2;
    localparam int LAT   = 2 + RT_W + NUM_W;
    localparam int EW    = rmq_pkg::ElemW;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [EW-1:0] m [9];
    for (genvar i = 0; i < 9; i++) begin : g_m
        assign m[i] = s_axis_tdata[i*EW +: EW];
    end

    logic [AW-1:0]                     arg;
    rmq_pkg::t_part                    part;
    logic signed [rmq_pkg::DiffW-1:0]  d [3];

    rmq_front #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_front (
        .i_clk(i_clk), .i_en(en), .i_m(m),
        .o_arg(arg), .o_part(part), .o_d(d)
    );

    localparam int SSW = 2 + 3 * rmq_pkg::DiffW;
    logic [SSW-1:0] sq_side_o;
    logic [RT_W-1:0] root;

    rmq_sqrt #(.AW(SQ_W), .SW(SSW)) u_sqrt (
        .i_clk(i_clk), .i_en(en),
        .i_a(SQ_W'(arg) << (FRAC_BITS - 2)),
        .i_side({part, d[2], d[1], d[0]}),
        .o_root(root), .o_side(sq_side_o)
    );

    logic signed [NUM_W-1:0] quo [3];
    logic [2+RT_W-1:0] dv_side [3];
    for (genvar i = 0; i < 3; i++) begin : g_div
        logic signed [rmq_pkg::DiffW-1:0] di;
        assign di = sq_side_o[i*rmq_pkg::DiffW +: rmq_pkg::DiffW];
        rmq_div #(.NW(NUM_W), .DW(DEN_W), .SW(2+RT_W)) u_div (
            .i_clk(i_clk), .i_en(en),
            .i_num(NUM_W'(di) <<< FRAC_BITS),
            .i_den(DEN_W'(root) << 2),
            .i_side({sq_side_o[SSW-1 -: 2], root}),
            .o_quo(quo[i]), .o_side(dv_side[i])
        );
    end

    function automatic logic [EW-1:0] sat(input logic signed [NUM_W-1:0] v);
        if (v > NUM_W'(rmq_pkg::OutMax)) return EW'(rmq_pkg::OutMax);
        if (v < NUM_W'(rmq_pkg::OutMin)) return EW'(rmq_pkg::OutMin);
        return EW'(v);
    endfunction

    logic [RT_W-1:0]  bg;
    rmq_pkg::t_part   pt;
    logic             dg;
    logic [EW-1:0]    bsat, one_sat, qa, qb, qc;
    logic [EW-1:0]    n_x, n_y, n_z, n_w;
    assign bg = dv_side[0][RT_W-1:0];
    assign pt = rmq_pkg::t_part'(dv_side[0][RT_W +: 2]);
    assign dg = (bg == '0);
    assign bsat    = sat(NUM_W'(bg));
    assign one_sat = sat(NUM_W'(1) <<< FRAC_BITS);
    assign qa = sat(quo[0]);
    assign qb = sat(quo[1]);
    assign qc = sat(quo[2]);

    always_comb begin
        if (dg) begin
            n_x = '0; n_y = '0; n_z = '0; n_w = one_sat;
        end else begin
            unique case (pt)
                rmq_pkg::PART_W: begin
                    n_x = qa; n_y = qb; n_z = qc; n_w = bsat;
                end
                rmq_pkg::PART_X: begin
                    n_x = bsat; n_y = qa; n_z = qb; n_w = qc;
                end
                rmq_pkg::PART_Y: begin
                    n_x = qa; n_y = bsat; n_z = qb; n_w = qc;
                end
                default: begin
                    n_x = qa; n_y = qb; n_z = bsat; n_w = qc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            r_vld         <= {r_vld[LAT-2:0], s_axis_tvalid};
            m_axis_tvalid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {5'd0, dg, pt, n_w, n_z, n_y, n_x};
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output side");
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[74] |-> m_axis_tdata[53:0] == '0)
        else $error("degenerate beat carries vector part");

endmodule

/* tb/tb_rotation_matrix_to_quaternion.sv */
// testbench for the matrix to quaternion converter: directed table, random matrices, scoreboard
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

    localparam int FRAC_BITS  = 16;
    localparam int ONE        = 1 << FRAC_BITS;
    localparam int N_RANDOM   = 1530;
    localparam int DRAIN      = 200;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [rmq_pkg::ElemW-1:0] t_elem;
    typedef t_elem t_matrix [9];

    typedef struct {
        t_elem          qx;
        t_elem          qy;
        t_elem          qz;
        t_elem          qw;
        rmq_pkg::t_part part;
        logic           degen;
    } t_quat;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [167:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [79:0]   m_axis_tdata;

    t_quat quat_fifo[$];
    int    err_count;
    int    cycle_count;
    int    stall_mode;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC_BITS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint int_sqrt(longint unsigned a);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > a) b = b >> 2;
        while (b != 0) begin
            if (a >= res + b) begin
                a = a - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic t_elem clip18(longint v);
        if (v > rmq_pkg::OutMax) v = rmq_pkg::OutMax;
        if (v < rmq_pkg::OutMin) v = rmq_pkg::OutMin;
        return t_elem'(v);
    endfunction

    function automatic t_quat to_quaternion(t_matrix mx);
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint cand [4];
        longint best, arg, big, den;
        longint qx, qy, qz, qw;
        int     sel;
        t_quat  q;
        m00 = mx[0]; m01 = mx[1]; m02 = mx[2];
        m10 = mx[3]; m11 = mx[4]; m12 = mx[5];
        m20 = mx[6]; m21 = mx[7]; m22 = mx[8];
        cand[0] = m00 + m11 + m22;
        cand[1] = m00 - m11 - m22;
        cand[2] = m11 - m00 - m22;
        cand[3] = m22 - m00 - m11;
        sel = 0;
        best = cand[0];
        for (int k = 1; k < 4; k++) begin
            if (cand[k] > best) begin
                best = cand[k];
                sel = k;
            end
        end
        arg = best + ONE;
        if (arg < 0) arg = 0;
        big = int_sqrt(longint'(arg) << (FRAC_BITS - 2));
        den = 4 * big;
        if (big == 0) begin
            qx = 0; qy = 0; qz = 0; qw = ONE;
        end else begin
            case (rmq_pkg::t_part'(sel))
                rmq_pkg::PART_W: begin
                    qx = ((m12 - m21) * ONE) / den;
                    qy = ((m20 - m02) * ONE) / den;
                    qz = ((m01 - m10) * ONE) / den;
                    qw = big;
                end
                rmq_pkg::PART_X: begin
                    qx = big;
                    qy = ((m01 + m10) * ONE) / den;
                    qz = ((m20 + m02) * ONE) / den;
                    qw = ((m12 - m21) * ONE) / den;
                end
                rmq_pkg::PART_Y: begin
                    qx = ((m01 + m10) * ONE) / den;
                    qy = big;
                    qz = ((m12 + m21) * ONE) / den;
                    qw = ((m20 - m02) * ONE) / den;
                end
                default: begin
                    qx = ((m20 + m02) * ONE) / den;
                    qy = ((m12 + m21) * ONE) / den;
                    qz = big;
                    qw = ((m01 - m10) * ONE) / den;
                end
            endcase
        end
        q.qx = clip18(qx);
        q.qy = clip18(qy);
        q.qz = clip18(qz);
        q.qw = clip18(qw);
        q.part = rmq_pkg::t_part'(sel);
        q.degen = (big == 0);
        return q;
    endfunction

    function automatic logic [167:0] pack_matrix(t_matrix mx);
        logic [167:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*rmq_pkg::ElemW +: rmq_pkg::ElemW] = mx[i];
        return d;
    endfunction

    function automatic t_matrix diag_matrix(int a, int b, int c);
        t_matrix mx;
        foreach (mx[i]) mx[i] = '0;
        mx[0] = t_elem'(a);
        mx[4] = t_elem'(b);
        mx[8] = t_elem'(c);
        return mx;
    endfunction

    function automatic t_matrix random_matrix();
        t_matrix mx;
        int      perm;
        int      sgn;
        if ($urandom_range(0, 1) == 0) begin
            foreach (mx[i]) mx[i] = t_elem'($urandom);
        end else begin
            // signed permutation matrix with noise, steers the choice of component
            foreach (mx[i]) mx[i] = t_elem'($urandom_range(0, 16384) - 8192);
            perm = $urandom_range(0, 2);
            for (int c = 0; c < 3; c++) begin
                sgn = $urandom_range(0, 1) ? ONE : -ONE;
                mx[c*3 + ((c + perm) % 3)] = t_elem'(sgn + int'($urandom_range(0, 4096)) - 2048);
            end
        end
        return mx;
    endfunction

    task automatic report_mismatch(string what, t_elem got, t_elem want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    task automatic send_matrix(t_matrix mx, bit typed, t_quat want);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_matrix(mx);
        do @(posedge i_clk); while (!s_axis_tready);
        quat_fifo.push_back(typed ? want : to_quaternion(mx));
    endtask

    always @(posedge i_clk) begin
        t_quat want;
        t_quat got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.qx    = m_axis_tdata[17:0];
            got.qy    = m_axis_tdata[35:18];
            got.qz    = m_axis_tdata[53:36];
            got.qw    = m_axis_tdata[71:54];
            got.part  = rmq_pkg::t_part'(m_axis_tdata[73:72]);
            got.degen = m_axis_tdata[74];
            if (quat_fifo.size() == 0) begin
                $display("unexpected output beat");
                err_count++;
            end else begin
                want = quat_fifo.pop_front();
                if (got.qx !== want.qx) report_mismatch("quat_x", got.qx, want.qx);
                if (got.qy !== want.qy) report_mismatch("quat_y", got.qy, want.qy);
                if (got.qz !== want.qz) report_mismatch("quat_z", got.qz, want.qz);
                if (got.qw !== want.qw) report_mismatch("quat_w", got.qw, want.qw);
                if (got.part !== want.part)
                    report_mismatch("largest_part", t_elem'(got.part), t_elem'(want.part));
                if (got.degen !== want.degen)
                    report_mismatch("degenerate", t_elem'(got.degen), t_elem'(want.degen));
            end
        end
    end

    // receiver: stretches of full rate alternate with random stalls
    always @(posedge i_clk) begin
        if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_rotation_matrix_to_quaternion failed");
            $finish;
        end
    end

    initial begin
        t_matrix mx;
        t_quat   want;
        err_count     = 0;
        cycle_count   = 0;
        stall_mode    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: identity and zero matrix typed in, the rest predicted
        for (int row = 0; row < 16; row++) begin
            want.qx    = '0;
            want.qy    = '0;
            want.qz    = '0;
            want.qw    = '0;
            want.part  = rmq_pkg::PART_W;
            want.degen = 1'b0;
            case (row)
                0:  mx = diag_matrix(ONE, ONE, ONE);
                1:  mx = diag_matrix(0, 0, 0);
                2:  mx = diag_matrix(ONE, -ONE, -ONE);
                3:  mx = diag_matrix(-ONE, ONE, -ONE);
                4:  mx = diag_matrix(-ONE, -ONE, ONE);
                5:  mx = diag_matrix(rmq_pkg::OutMax, rmq_pkg::OutMax, rmq_pkg::OutMax);
                6:  mx = diag_matrix(rmq_pkg::OutMin, rmq_pkg::OutMin, rmq_pkg::OutMin);
                7:  mx = diag_matrix(rmq_pkg::OutMax, rmq_pkg::OutMin, rmq_pkg::OutMin);
                8:  mx = diag_matrix(rmq_pkg::OutMin, rmq_pkg::OutMax, rmq_pkg::OutMin);
                9:  mx = diag_matrix(rmq_pkg::OutMin, rmq_pkg::OutMin, rmq_pkg::OutMax);
                10: mx = diag_matrix(0, 0, 0); // ties between w and the others
                11: begin
                    foreach (mx[i]) mx[i] = t_elem'(rmq_pkg::OutMax);
                end
                12: begin
                    foreach (mx[i]) mx[i] = t_elem'(rmq_pkg::OutMin);
                end
                13: begin
                    mx = diag_matrix(0, 0, 0);
                    mx[5] = t_elem'(rmq_pkg::OutMax); mx[7] = t_elem'(rmq_pkg::OutMin);
                    mx[6] = t_elem'(rmq_pkg::OutMax); mx[2] = t_elem'(rmq_pkg::OutMin);
                    mx[1] = t_elem'(rmq_pkg::OutMax); mx[3] = t_elem'(rmq_pkg::OutMin);
                end
                14: begin
                    mx = diag_matrix(0, 0, 0);
                    mx[5] = t_elem'(rmq_pkg::OutMin); mx[7] = t_elem'(rmq_pkg::OutMax);
                    mx[6] = t_elem'(rmq_pkg::OutMin); mx[2] = t_elem'(rmq_pkg::OutMax);
                    mx[1] = t_elem'(rmq_pkg::OutMin); mx[3] = t_elem'(rmq_pkg::OutMax);
                end
                default: begin
                    mx = diag_matrix(0, ONE, ONE); // w, y and z tie, w wins
                    mx[0] = t_elem'(-ONE);
                end
            endcase
            if (row == 0) begin
                want.qw = t_elem'(ONE);
                want.part = rmq_pkg::PART_W;
                send_matrix(mx, 1'b1, want);
            end else if (row == 1) begin
                want.qw = t_elem'(ONE / 2);
                want.part = rmq_pkg::PART_W;
                send_matrix(mx, 1'b1, want);
            end else begin
                send_matrix(mx, 1'b0, want);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            mx = random_matrix();
            send_matrix(mx, 1'b0, want);
        end
        s_axis_tvalid <= 1'b0;

        while (quat_fifo.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_rotation_matrix_to_quaternion passed");
        end else begin
            $display("tb_rotation_matrix_to_quaternion failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/tb_rotation_matrix_to_quaternion.sv
